// ===== rtl/tcw_pkg.sv =====
// shared types and constants of the text console character writer
package tcw_pkg;

    localparam int OPCODE_W  = 2;
    localparam int CHAR_W    = 8;
    localparam int INDEX_W   = 11;
    localparam int CELL_W    = 16;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;
    localparam int POS_OUT_W = 11;
    localparam int ATTR_W    = 8;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register word index
    localparam logic REG_TEXT_ATTR = 1'b0;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    typedef enum logic [2:0] {
        K_PUT       = 3'd0,
        K_NEWLINE   = 3'd1,
        K_RETURN    = 3'd2,
        K_BACKSPACE = 3'd3,
        K_CLEAR     = 3'd4,
        K_READ      = 3'd5,
        K_NOP       = 3'd6
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [CHAR_W-1:0]   char_code;
        logic [INDEX_W-1:0]  cell_index;
    } cmd_t;

endpackage

// ===== rtl/tcw_in_if.sv =====
// request channel: one word per console operation
interface tcw_in_if;
    logic                             valid;
    logic                             ready;
    logic [tcw_pkg::OPCODE_W-1:0]     opcode;
    logic [tcw_pkg::CHAR_W-1:0]       char_code;
    logic [tcw_pkg::INDEX_W-1:0]      cell_index;

    modport source (output valid, output opcode, output char_code, output cell_index,
                    input ready);
    modport sink   (input valid, input opcode, input char_code, input cell_index,
                    output ready);
endinterface

// ===== rtl/tcw_out_if.sv =====
// response channel: one word per finished operation
interface tcw_out_if;
    logic                             valid;
    logic                             ready;
    logic [tcw_pkg::CELL_W-1:0]       cell_value;
    logic [tcw_pkg::ROW_OUT_W-1:0]    cursor_row;
    logic [tcw_pkg::COL_OUT_W-1:0]    cursor_column;
    logic [tcw_pkg::POS_OUT_W-1:0]    cursor_position;

    modport source (output valid, output cell_value, output cursor_row,
                    output cursor_column, output cursor_position, input ready);
    modport sink   (input valid, input cell_value, input cursor_row,
                    input cursor_column, input cursor_position, output ready);
endinterface

// ===== rtl/tcw_ram.sv =====
// generic single write port ram with registered read
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tcw_front.sv =====
// front end: takes request words, decodes them and queues commands
module tcw_front (
    input  logic          clk,
    input  logic          rst_n,
    tcw_in_if.sink        request,
    output logic          cmd_valid,
    output tcw_pkg::cmd_t cmd,
    input  logic          cmd_pop
);

    localparam int QDEPTH = 2;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    tcw_pkg::cmd_t    q_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    tcw_pkg::cmd_t    decoded;

    function automatic tcw_pkg::kind_t classify(
        input logic [tcw_pkg::OPCODE_W-1:0] op,
        input logic [tcw_pkg::CHAR_W-1:0]   ch
    );
        tcw_pkg::kind_t k;
        k = tcw_pkg::K_NOP;
        case (op)
            tcw_pkg::OP_PUT:
            begin
                if (ch == tcw_pkg::CH_NEWLINE)
                    k = tcw_pkg::K_NEWLINE;
                else if (ch == tcw_pkg::CH_RETURN)
                    k = tcw_pkg::K_RETURN;
                else if (ch == tcw_pkg::CH_BACKSPACE)
                    k = tcw_pkg::K_BACKSPACE;
                else
                    k = tcw_pkg::K_PUT;
            end
            tcw_pkg::OP_CLEAR: k = tcw_pkg::K_CLEAR;
            tcw_pkg::OP_READ:  k = tcw_pkg::K_READ;
            default:           k = tcw_pkg::K_NOP;
        endcase
        return k;
    endfunction

    assign request.ready = (count_reg != CNT_W'(QDEPTH));
    assign push          = request.valid && request.ready;
    assign cmd_valid     = (count_reg != '0);
    assign cmd           = q_reg[rd_ptr_reg];

    always_comb
    begin
        decoded.kind       = classify(request.opcode, request.char_code);
        decoded.char_code  = request.char_code;
        decoded.cell_index = request.cell_index;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !cmd_pop)
            count_next = count_reg + CNT_W'(1);
        else if (!push && cmd_pop)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

// ===== rtl/tcw_back.sv =====
// back end: cursor, cell store, scroll and clear sequencer, response register
module tcw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [tcw_pkg::ATTR_W-1:0]  attr,
    input  logic                        cmd_valid,
    input  tcw_pkg::cmd_t               cmd,
    output logic                        cmd_pop,
    tcw_out_if.source                   response
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    localparam logic [AW-1:0] COPY_END  = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_READ   = 6'b000010,
        S_COPY   = 6'b000100,
        S_BLANK  = 6'b001000,
        S_CLEAR  = 6'b010000,
        S_RESULT = 6'b100000
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [RW-1:0]                 row_reg;
    logic [RW-1:0]                 row_next;
    logic [CW-1:0]                 col_reg;
    logic [CW-1:0]                 col_next;
    logic [AW-1:0]                 pos_reg;
    logic [AW-1:0]                 pos_next;
    logic [AW-1:0]                 scan_reg;
    logic [AW-1:0]                 scan_next;
    logic                          rd_ok_reg;
    logic                          rd_ok_next;
    logic [tcw_pkg::CELL_W-1:0]    value_reg;
    logic [tcw_pkg::CELL_W-1:0]    value_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [tcw_pkg::CELL_W-1:0]    out_value_reg;
    logic [tcw_pkg::ROW_OUT_W-1:0] out_row_reg;
    logic [tcw_pkg::COL_OUT_W-1:0] out_col_reg;
    logic [tcw_pkg::POS_OUT_W-1:0] out_pos_reg;
    logic                          load_out;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [tcw_pkg::CELL_W-1:0]    ram_wdata;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [tcw_pkg::CELL_W-1:0]    ram_rdata;

    logic [tcw_pkg::CELL_W-1:0]    blank;
    logic [AW-1:0]                 col_ext;
    logic                          at_last_row;
    logic                          index_ok;

    assign blank       = {attr, tcw_pkg::CH_SPACE};
    assign col_ext     = AW'(col_reg);
    assign at_last_row = (row_reg == LAST_ROW);
    assign index_ok    = (32'(cmd.cell_index) < 32'(CELLS));

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        pos_next   = pos_reg;
        scan_next  = scan_reg;
        rd_ok_next = rd_ok_reg;
        value_next = value_reg;
        cmd_pop    = 1'b0;
        load_out   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    value_next = '0;
                    state_next = S_RESULT;
                    case (cmd.kind)
                        tcw_pkg::K_PUT:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = pos_reg;
                            ram_wdata = {attr, cmd.char_code};
                            if (col_reg == LAST_COL)
                            begin
                                col_next = '0;
                                if (at_last_row)
                                begin
                                    // wrap off the bottom: land on the start of the last row
                                    pos_next   = pos_reg + AW'(1) - ROW_STEP;
                                    scan_next  = '0;
                                    state_next = S_COPY;
                                end
                                else
                                begin
                                    row_next = row_reg + RW'(1);
                                    pos_next = pos_reg + AW'(1);
                                end
                            end
                            else
                            begin
                                col_next = col_reg + CW'(1);
                                pos_next = pos_reg + AW'(1);
                            end
                        end
                        tcw_pkg::K_NEWLINE:
                        begin
                            col_next = '0;
                            if (at_last_row)
                            begin
                                pos_next   = pos_reg - col_ext;
                                scan_next  = '0;
                                state_next = S_COPY;
                            end
                            else
                            begin
                                row_next = row_reg + RW'(1);
                                pos_next = pos_reg - col_ext + ROW_STEP;
                            end
                        end
                        tcw_pkg::K_RETURN:
                        begin
                            col_next = '0;
                            pos_next = pos_reg - col_ext;
                        end
                        tcw_pkg::K_BACKSPACE:
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = blank;
                            ram_waddr = pos_reg;
                            if (col_reg != '0)
                            begin
                                col_next  = col_reg - CW'(1);
                                pos_next  = pos_reg - AW'(1);
                                ram_waddr = pos_reg - AW'(1);
                            end
                            else if (row_reg != '0)
                            begin
                                row_next  = row_reg - RW'(1);
                                col_next  = LAST_COL;
                                pos_next  = pos_reg - AW'(1);
                                ram_waddr = pos_reg - AW'(1);
                            end
                        end
                        tcw_pkg::K_CLEAR:
                        begin
                            row_next   = '0;
                            col_next   = '0;
                            pos_next   = '0;
                            scan_next  = '0;
                            state_next = S_CLEAR;
                        end
                        tcw_pkg::K_READ:
                        begin
                            ram_re     = index_ok;
                            ram_raddr  = AW'(cmd.cell_index);
                            rd_ok_next = index_ok;
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                value_next = rd_ok_reg ? ram_rdata : '0;
                state_next = S_RESULT;
            end
            S_COPY:
            begin
                // read one row ahead, write back the word read in the previous cycle
                if (scan_reg < COPY_END)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = scan_reg + ROW_STEP;
                end
                if (scan_reg != '0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = scan_reg - AW'(1);
                    ram_wdata = ram_rdata;
                end
                if (scan_reg == COPY_END)
                    state_next = S_BLANK;
                else
                    scan_next = scan_reg + AW'(1);
            end
            S_BLANK, S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = scan_reg;
                ram_wdata = blank;
                if (scan_reg == LAST_CELL)
                    state_next = S_RESULT;
                else
                    scan_next = scan_reg + AW'(1);
            end
            S_RESULT:
            begin
                if (!out_valid_reg || response.ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (response.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg  <= scan_next;
        rd_ok_reg <= rd_ok_next;
        value_reg <= value_next;
        if (load_out)
        begin
            out_value_reg <= value_reg;
            out_row_reg   <= tcw_pkg::ROW_OUT_W'(row_reg);
            out_col_reg   <= tcw_pkg::COL_OUT_W'(col_reg);
            out_pos_reg   <= tcw_pkg::POS_OUT_W'(pos_reg);
        end
    end

    assign response.valid           = out_valid_reg;
    assign response.cell_value      = out_value_reg;
    assign response.cursor_row      = out_row_reg;
    assign response.cursor_column   = out_col_reg;
    assign response.cursor_position = out_pos_reg;

`ifndef ASSERT_OFF
    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> state_reg == S_IDLE)
        else $error("command taken outside idle");

    a_pos_tracks_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> 32'(pos_reg) == 32'(row_reg) * COLUMNS + 32'(col_reg))
        else $error("linear position out of step with row and column");

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(row_reg) < ROWS && 32'(col_reg) < COLUMNS)
        else $error("cursor off screen");

    a_clear_homes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && scan_reg == LAST_CELL) |=> pos_reg == '0)
        else $error("clear did not home the cursor");
`endif

endmodule

// ===== rtl/text_console_char_writer.sv =====
// top level of the text console character writer
//
//  channel    | dir | handshake       | word
//  -----------+-----+-----------------+----------------------------------------------
//  request    | in  | valid/ready     | opcode, char_code, cell_index
//  response   | out | valid/ready     | cell_value, cursor_row/column/position
//  apb        | in  | psel/penable    | text_attribute at word 0
//
//  put, newline, return, backspace and unused opcodes go from idle to the result state;
//  a read passes a read state first; a clear and a scroll (copy, then blank) walk the
//  cell ram through its single write port, one cell per cycle
//  reset homes the cursor and sets the attribute to 0x0F; cells hold garbage until a clear
//  a two-word command queue and the response register let each side stall on its own
module text_console_char_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                             clk,
    input  logic                             rst_n,
    tcw_in_if.sink                           request,
    tcw_out_if.source                        response,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    logic [tcw_pkg::ATTR_W-1:0] attr_reg;
    logic [tcw_pkg::ATTR_W-1:0] attr_next;
    logic                       attr_sel;
    logic                       cmd_valid;
    logic                       cmd_pop;
    tcw_pkg::cmd_t              cmd;

    assign pready   = 1'b1;
    assign attr_sel = (paddr[tcw_pkg::APB_ADDR_W-1] == tcw_pkg::REG_TEXT_ATTR);

    always_comb
    begin
        attr_next = attr_reg;
        if (psel && penable && pwrite && attr_sel)
            attr_next = pwdata[tcw_pkg::ATTR_W-1:0];
    end

    always_comb
    begin
        prdata = '0;
        if (attr_sel)
            prdata = tcw_pkg::APB_DATA_W'(attr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            attr_reg <= tcw_pkg::ATTR_RESET;
        else
            attr_reg <= attr_next;
    end

    tcw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .attr      (attr_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .response  (response)
    );

endmodule
